// ----- rtl/masked_row_mean_subtract_core_macros.svh -----
// Assertion macros shared by the verification code of masked_row_mean_subtract_core.
// No dependencies; each macro places one labeled concurrent assertion on a rising clock.
`ifndef MASKED_ROW_MEAN_SUBTRACT_CORE_MACROS_SVH
`define MASKED_ROW_MEAN_SUBTRACT_CORE_MACROS_SVH

// Plain property, disabled while reset is asserted.
`define MRMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, disabled while reset is asserted.
`define MRMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/mrms_pkg.sv -----
// Shared types and constants for the masked row mean subtract core.
// No dependencies; imported by every module of the block.
package mrms_pkg;

    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int CFG_BITS   = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_BITS-1:0] ROW_LENGTH_RST = 7'd64;

    // Register index decoded from paddr[APB_ADDR_W-1:2].
    localparam logic [APB_ADDR_W-3:0] REG_ROW_LENGTH = 1'b0;

    // Occupancy flags of the row descriptor queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT,
        BK_EMPTY
    } t_back_state;

endpackage

// ----- rtl/mrms_front.sv -----
// Front end: accepts samples, stores them in the row buffer, accumulates the masked sum
// and count, and pushes one row descriptor per finished row. Depends on mrms_pkg.
module mrms_front #(
    parameter int MAX_COLS    = mrms_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = mrms_pkg::DEF_SAMPLE_BITS,
    localparam int CNT_W  = $clog2(MAX_COLS + 1),
    localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int SUM_W  = SAMPLE_BITS + CNT_W,
    localparam int DESC_W = SUM_W + 2 * CNT_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [mrms_pkg::CFG_BITS-1:0]      i_row_length,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_mask_bit,
    output logic                               o_wr_en,
    output logic [IDX_W:0]                     o_wr_addr,
    output logic signed [SAMPLE_BITS-1:0]      o_wr_data,
    input  mrms_pkg::t_q_status                i_q_status,
    output logic                               o_q_push,
    output logic [DESC_W-1:0]                  o_q_data
);
    import mrms_pkg::*;

    logic [CNT_W-1:0]        r_col;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_bank;

    logic [CNT_W-1:0]        eff_len;
    logic [CNT_W-1:0]        n_col;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [SUM_W-1:0] n_sum;
    logic                    accept;
    logic                    row_done;

    always_comb begin
        if (i_row_length == '0) begin
            eff_len = CNT_W'(1);
        end else if (int'(i_row_length) > MAX_COLS) begin
            eff_len = CNT_W'(MAX_COLS);
        end else begin
            eff_len = CNT_W'(i_row_length);
        end
    end

    // The bank being filled is free unless both banks already hold finished rows.
    assign o_ready  = !i_q_status.full;
    assign accept   = i_valid && o_ready;

    assign n_col    = r_col + 1'b1;
    assign n_cnt    = i_mask_bit ? r_cnt + 1'b1 : r_cnt;
    assign n_sum    = i_mask_bit ? r_sum + SUM_W'(i_sample) : r_sum;
    assign row_done = (n_col >= eff_len);

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_bank, r_col[IDX_W-1:0]};
    assign o_wr_data = i_sample;

    assign o_q_push  = accept && row_done;
    assign o_q_data  = {n_sum, n_cnt, n_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_bank <= 1'b0;
        end else if (accept) begin
            if (row_done) begin
                r_col  <= '0;
                r_cnt  <= '0;
                r_sum  <= '0;
                r_bank <= !r_bank;
            end else begin
                r_col  <= n_col;
                r_cnt  <= n_cnt;
                r_sum  <= n_sum;
            end
        end
    end

endmodule

// ----- rtl/mrms_fifo.sv -----
// Two-entry queue of row descriptors between the front end and the back end.
// Depends on mrms_pkg for the status struct.
module mrms_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output mrms_pkg::t_q_status  o_status
);
    import mrms_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/mrms_div.sv -----
// Restoring divider producing one quotient bit per cycle for the row mean.
// Unsigned operands; the caller handles signs. Depends on mrms_pkg.
module mrms_div #(
    parameter int SUM_W = 31,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);
    import mrms_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_quot;
    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    rem_sh;
    logic              fits;

    assign rem_sh     = {r_rem[CNT_W-1:0], r_quot[SUM_W-1]};
    assign fits       = (rem_sh >= {1'b0, r_div});
    assign o_done     = r_done;
    assign o_quotient = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[SUM_W-2:0], fits};
            r_rem  <= fits ? rem_sh - {1'b0, r_div} : rem_sh;
        end
    end

endmodule

// ----- rtl/mrms_back.sv -----
// Back end: owns the double-banked row buffer, divides a row's sum by a nonzero count
// and emits the centered samples, else an empty result. Uses mrms_pkg and mrms_div.
module mrms_back #(
    parameter int MAX_COLS    = mrms_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = mrms_pkg::DEF_SAMPLE_BITS,
    localparam int CNT_W  = $clog2(MAX_COLS + 1),
    localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int SUM_W  = SAMPLE_BITS + CNT_W,
    localparam int DESC_W = SUM_W + 2 * CNT_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [IDX_W:0]                 i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]  i_wr_data,
    input  mrms_pkg::t_q_status            i_q_status,
    input  logic [DESC_W-1:0]              i_q_data,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_BITS:0]    o_centered,
    output logic signed [SAMPLE_BITS-1:0]  o_row_mean,
    output logic                           o_row_empty,
    output logic                           o_last_of_row
);
    import mrms_pkg::*;

    localparam int MEM_D = 2 ** (IDX_W + 1);

    logic signed [SAMPLE_BITS-1:0] r_mem [MEM_D];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    t_back_state                   r_state;
    t_back_state                   n_state;
    logic                          r_bank;
    logic                          r_rd_pend;
    logic                          r_rd_last;
    logic [CNT_W-1:0]              r_k;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS:0]   r_out_centered;
    logic signed [SAMPLE_BITS-1:0] r_out_mean;
    logic                          r_out_empty;
    logic                          r_out_last;

    logic [SUM_W-1:0]              desc_sum;
    logic [CNT_W-1:0]              desc_cnt;
    logic [CNT_W-1:0]              desc_n;
    logic [SUM_W-1:0]              div_mag;
    logic                          div_start;
    logic                          div_done;
    logic [SUM_W-1:0]              div_quot;
    logic [SUM_W-1:0]              mean_full;
    logic [CNT_W-1:0]              k_inc;
    logic                          slot_free;
    logic                          issue;
    logic                          load_data;
    logic                          load_empty;

    assign desc_sum = i_q_data[DESC_W-1 -: SUM_W];
    assign desc_cnt = i_q_data[2*CNT_W-1:CNT_W];
    assign desc_n   = i_q_data[CNT_W-1:0];

    assign div_mag   = desc_sum[SUM_W-1] ? (~desc_sum + 1'b1) : desc_sum;
    assign mean_full = desc_sum[SUM_W-1] ? (~div_quot + 1'b1) : div_quot;
    assign k_inc     = r_k + 1'b1;
    assign slot_free = !r_out_valid || i_ready;

    mrms_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (desc_cnt),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = (desc_cnt == '0) ? BK_EMPTY : BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (r_rd_pend && r_rd_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_EMPTY: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // One buffer read is in flight at a time, so a read is issued only when the
    // output register will be free by the time its data returns.
    always_comb begin
        div_start  = (r_state == BK_IDLE) && !i_q_status.empty && (desc_cnt != '0);
        issue      = (r_state == BK_EMIT) && (r_k < desc_n) && !r_rd_pend && slot_free;
        load_data  = r_rd_pend;
        load_empty = (r_state == BK_EMPTY) && slot_free;
        o_q_pop    = (r_rd_pend && r_rd_last) || load_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_bank      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= issue;
            if (div_done) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= k_inc;
            end
            if (o_q_pop) begin
                r_bank <= !r_bank;
            end
            if (load_data || load_empty) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_bank, r_k[IDX_W-1:0]}];
            r_rd_last <= (k_inc == desc_n);
        end
        if (div_done) begin
            r_mean <= mean_full[SAMPLE_BITS-1:0];
        end
        if (load_data) begin
            r_out_centered <= (SAMPLE_BITS + 1)'(r_rd_data) - (SAMPLE_BITS + 1)'(r_mean);
            r_out_mean     <= r_mean;
            r_out_empty    <= 1'b0;
            r_out_last     <= r_rd_last;
        end else if (load_empty) begin
            r_out_centered <= '0;
            r_out_mean     <= '0;
            r_out_empty    <= 1'b1;
            r_out_last     <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_centered    = r_out_centered;
    assign o_row_mean    = r_out_mean;
    assign o_row_empty   = r_out_empty;
    assign o_last_of_row = r_out_last;

endmodule

// ----- rtl/masked_row_mean_subtract_core.sv -----
// Results: a row's results follow its last sample once the one-bit-per-cycle mean divider
// has finished, and the back end keeps only one buffer read in flight at a time.
// Throughput: samples enter one per cycle while one of the two row buffer banks is free.
// Reset: synchronous, active low; clears control state and sets row_length to 64.
// The row buffer is not cleared and needs no clearing pass.
module masked_row_mean_subtract_core #(
    parameter int MAX_COLS    = mrms_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = mrms_pkg::DEF_SAMPLE_BITS,
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mrms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mrms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mrms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [IN_TDATA_W-1:0]            s_axis_tdata,  // sample
    input  logic                             s_axis_tuser,  // mask_bit
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [OUT_TDATA_W-1:0]           m_axis_tdata,  // centered, row_mean
    output logic                             m_axis_tuser,  // row_empty
    output logic                             m_axis_tlast   // last_of_row
);
    import mrms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int DESC_W = SUM_W + 2 * CNT_W;

    logic [CFG_BITS-1:0]           r_row_length;
    logic [APB_ADDR_W-3:0]         reg_idx;
    logic                          cfg_write;

    logic                          wr_en;
    logic [IDX_W:0]                wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    t_q_status                     q_status;
    logic                          q_push;
    logic                          q_pop;
    logic [DESC_W-1:0]             q_in;
    logic [DESC_W-1:0]             q_out;
    logic signed [SAMPLE_BITS:0]   centered;
    logic signed [SAMPLE_BITS-1:0] row_mean;

    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == REG_ROW_LENGTH) ? APB_DATA_W'(r_row_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LENGTH_RST;
        end else if (cfg_write && (reg_idx == REG_ROW_LENGTH)) begin
            r_row_length <= pwdata[CFG_BITS-1:0];
        end
    end

    mrms_front #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_length (r_row_length),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_mask_bit   (s_axis_tuser),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_q_status   (q_status),
        .o_q_push     (q_push),
        .o_q_data     (q_in)
    );

    mrms_fifo #(
        .WIDTH (DESC_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    mrms_back #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .i_q_status    (q_status),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_centered    (centered),
        .o_row_mean    (row_mean),
        .o_row_empty   (m_axis_tuser),
        .o_last_of_row (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'({row_mean, centered});

endmodule

// ----- rtl/mrms_checker.sv -----
// Port-level checker for masked_row_mean_subtract_core, attached by the bind below.
// Depends on mrms_pkg and masked_row_mean_subtract_core_macros.svh.
`include "masked_row_mean_subtract_core_macros.svh"

module mrms_checker #(
    parameter int MAX_COLS    = mrms_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS = mrms_pkg::DEF_SAMPLE_BITS,
    localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [mrms_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [mrms_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [mrms_pkg::APB_DATA_W-1:0]  prdata,
    input logic                             pready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [OUT_TDATA_W-1:0]           m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);
    import mrms_pkg::*;

    logic signed [SAMPLE_BITS+1:0] recon;
    logic                          cfg_wr0;

    // Centered value plus mean gives back the stored sample, which must fit the sample width.
    assign recon = (SAMPLE_BITS + 2)'($signed(m_axis_tdata[SAMPLE_BITS:0]))
                 + (SAMPLE_BITS + 2)'($signed(m_axis_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1]));
    assign cfg_wr0 = psel && penable && pwrite && pready && (paddr == '0);

    `MRMS_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "result changed while stalled")
    `MRMS_ASSERT_IMP(a_empty_form, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "empty row result not marked last or not zero")
    `MRMS_ASSERT_IMP(a_recon_range, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, (recon[SAMPLE_BITS+1:SAMPLE_BITS-1] == '0) || (recon[SAMPLE_BITS+1:SAMPLE_BITS-1] == '1), "centered plus mean is outside the sample range")
    `MRMS_ASSERT(a_cfg_readback, i_clk, i_rst_n, cfg_wr0 |=> ((paddr != '0) || (prdata[CFG_BITS-1:0] == $past(pwdata[CFG_BITS-1:0]))), "row_length readback differs from the value written")

endmodule

bind masked_row_mean_subtract_core mrms_checker #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mrms_checker (.*);
